// ===== rtl/threshold_wait_counter_defines.svh =====
// Assertion macros shared by the threshold wait counter checker.
`ifndef THRESHOLD_WAIT_COUNTER_DEFINES_SVH
`define THRESHOLD_WAIT_COUNTER_DEFINES_SVH

// Same-cycle implication, inactive while reset is asserted.
`define TWC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define TWC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define TWC_ASSERT_RST(name, clk, ante, cons, msg) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/twc_pkg.sv =====
// Package with types, codes and sizes of the threshold wait counter.
package twc_pkg;

    localparam int WAIT_SLOTS   = 32;
    localparam int SLOT_W       = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
    localparam int REQ_W        = 3;
    localparam int VAL_W        = 64;
    localparam int TAG_W        = 8;
    localparam int KIND_W       = 2;
    localparam int SLOT_FIELD_W = 5;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CMD_W        = 2;

    localparam logic [REQ_W-1:0] REQ_SET   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RAISE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INC   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WAIT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ACK        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WOKEN      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REGISTERED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REJECTED   = 2'd3;

    localparam logic [CMD_W-1:0] CMD_ACK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WAKE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MET  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_WAIT = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic [VAL_W-1:0] count;
        logic [VAL_W-1:0] threshold;
        logic [TAG_W-1:0] tag;
    } t_cmd;

    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [63:0] wide;
        wide = 64'(idx);
        return wide[SLOT_FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/threshold_wait_counter.sv =====
// Top level of the threshold wait counter: front end, command queue and back end.
//
//  channel   handshake                 payload
//  request   i_start / o_busy          i_req_type, i_operand_value, i_requester_tag
//  result    o_result_valid (strobe)   o_result_kind, o_slot_index, o_woken_tag,
//                                      o_counter_value, o_last
//
// A read, a wait or a raise without change gives its one result through the front
// stage, the queue and the result register; the front end and the queue take a new
// request every cycle while the back end keeps up. A counter change runs a wake scan
// that visits each occupied slot of the threshold memory in turn, in a read state and
// a compare state, then gives a final acknowledge. Reset is synchronous and clears the
// counter and all slot occupancy bits at once. The receiver cannot stall; o_busy rises
// only when the front stage holds a request and the queue is full.
module threshold_wait_counter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [twc_pkg::REQ_W-1:0]        i_req_type,
    input  logic [twc_pkg::VAL_W-1:0]        i_operand_value,
    input  logic [twc_pkg::TAG_W-1:0]        i_requester_tag,
    output logic                             o_result_valid,
    output logic [twc_pkg::KIND_W-1:0]       o_result_kind,
    output logic [twc_pkg::SLOT_FIELD_W-1:0] o_slot_index,
    output logic [twc_pkg::TAG_W-1:0]        o_woken_tag,
    output logic [twc_pkg::VAL_W-1:0]        o_counter_value,
    output logic                             o_last
);
    import twc_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    twc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_req_type      (i_req_type),
        .i_operand_value (i_operand_value),
        .i_requester_tag (i_requester_tag),
        .o_push          (push),
        .o_push_cmd      (push_cmd),
        .i_full          (full)
    );

    twc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (full),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_head_cmd (head_cmd)
    );

    twc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_head_cmd      (head_cmd),
        .o_pop           (pop),
        .o_result_valid  (o_result_valid),
        .o_result_kind   (o_result_kind),
        .o_slot_index    (o_slot_index),
        .o_woken_tag     (o_woken_tag),
        .o_counter_value (o_counter_value),
        .o_last          (o_last)
    );

endmodule

// ===== rtl/twc_front.sv =====
// Front end: takes requests, owns the counter and classifies each request into a command.
module twc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [twc_pkg::REQ_W-1:0] i_req_type,
    input  logic [twc_pkg::VAL_W-1:0] i_operand_value,
    input  logic [twc_pkg::TAG_W-1:0] i_requester_tag,
    output logic                      o_push,
    output twc_pkg::t_cmd             o_push_cmd,
    input  logic                      i_full
);
    import twc_pkg::*;

    logic             r_fv;
    logic             n_fv;
    logic [REQ_W-1:0] r_req;
    logic [VAL_W-1:0] r_operand;
    logic [TAG_W-1:0] r_tag;
    logic [VAL_W-1:0] r_counter;
    logic [VAL_W-1:0] n_counter;
    logic             accept;
    t_cmd             cmd;

    assign o_busy = r_fv & i_full;
    assign accept = i_start & ~o_busy;
    assign o_push = r_fv & ~i_full;
    assign o_push_cmd = cmd;

    always_comb begin
        n_counter     = r_counter;
        cmd.op        = CMD_ACK;
        cmd.threshold = r_operand;
        cmd.tag       = r_tag;
        case (r_req)
            REQ_SET: begin
                n_counter = r_operand;
                cmd.op    = CMD_WAKE;
            end
            REQ_RAISE: begin
                if (r_counter < r_operand) begin
                    n_counter = r_operand;
                    cmd.op    = CMD_WAKE;
                end
            end
            REQ_INC: begin
                n_counter = r_counter + 64'd1;
                cmd.op    = CMD_WAKE;
            end
            REQ_WAIT: begin
                cmd.op = (r_counter >= r_operand) ? CMD_MET : CMD_WAIT;
            end
            REQ_READ: begin
                cmd.op = CMD_ACK;
            end
            default: begin
                cmd.op = CMD_ACK;
            end
        endcase
        cmd.count = n_counter;
    end

    always_comb begin
        n_fv = r_fv;
        if (accept) begin
            n_fv = 1'b1;
        end else if (o_push) begin
            n_fv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv      <= 1'b0;
            r_counter <= '0;
        end else begin
            r_fv <= n_fv;
            if (o_push) begin
                r_counter <= n_counter;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= i_req_type;
            r_operand <= i_operand_value;
            r_tag     <= i_requester_tag;
        end
    end

endmodule

// ===== rtl/twc_queue.sv =====
// Short command queue between the front end and the back end.
module twc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  twc_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output twc_pkg::t_cmd o_head_cmd
);
    import twc_pkg::*;

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QPTR_W:0]   FULL_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

    t_cmd              r_entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;

    assign o_full     = (r_count == FULL_CNT);
    assign o_empty    = (r_count == '0);
    assign o_head_cmd = r_entries[r_head];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_tail <= (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_tail] <= i_push_cmd;
        end
    end

endmodule

// ===== rtl/twc_back.sv =====
// Back end: keeps the waiter table, registers waits, scans for wakes and drives results.
module twc_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_empty,
    input  twc_pkg::t_cmd                    i_head_cmd,
    output logic                             o_pop,
    output logic                             o_result_valid,
    output logic [twc_pkg::KIND_W-1:0]       o_result_kind,
    output logic [twc_pkg::SLOT_FIELD_W-1:0] o_slot_index,
    output logic [twc_pkg::TAG_W-1:0]        o_woken_tag,
    output logic [twc_pkg::VAL_W-1:0]        o_counter_value,
    output logic                             o_last
);
    import twc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;

    logic [VAL_W-1:0]        r_thr_mem [WAIT_SLOTS];
    logic [TAG_W-1:0]        r_tag_mem [WAIT_SLOTS];

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [WAIT_SLOTS-1:0]   r_occ;
    logic [WAIT_SLOTS-1:0]   n_occ;
    logic [WAIT_SLOTS-1:0]   r_pend;
    logic [WAIT_SLOTS-1:0]   n_pend;
    logic [VAL_W-1:0]        r_cnt;
    logic [VAL_W-1:0]        n_cnt;
    logic [SLOT_W-1:0]       r_idx;
    logic [SLOT_W-1:0]       n_idx;
    logic [VAL_W-1:0]        r_rd_thr;
    logic [TAG_W-1:0]        r_rd_tag;

    logic                    free_found;
    logic [SLOT_W-1:0]       free_idx;
    logic                    pend_found;
    logic [SLOT_W-1:0]       pend_idx;
    logic                    mem_we;
    logic                    rd_en;

    logic                    emit;
    logic [KIND_W-1:0]       e_kind;
    logic [SLOT_FIELD_W-1:0] e_slot;
    logic [TAG_W-1:0]        e_tag;
    logic [VAL_W-1:0]        e_count;
    logic                    e_last;

    logic                    r_out_valid;
    logic [KIND_W-1:0]       r_out_kind;
    logic [SLOT_FIELD_W-1:0] r_out_slot;
    logic [TAG_W-1:0]        r_out_tag;
    logic [VAL_W-1:0]        r_out_count;
    logic                    r_out_last;

    assign o_pop           = (r_state == ST_IDLE) && !i_empty;
    assign o_result_valid  = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_slot_index    = r_out_slot;
    assign o_woken_tag     = r_out_tag;
    assign o_counter_value = r_out_count;
    assign o_last          = r_out_last;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        pend_found = 1'b0;
        pend_idx   = '0;
        for (int i = WAIT_SLOTS - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
            if (r_pend[i]) begin
                pend_found = 1'b1;
                pend_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        mem_we  = 1'b0;
        rd_en   = 1'b0;
        emit    = 1'b0;
        e_kind  = KIND_ACK;
        e_slot  = '0;
        e_tag   = '0;
        e_count = r_cnt;
        e_last  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    e_count = i_head_cmd.count;
                    case (i_head_cmd.op)
                        CMD_MET: begin
                            emit   = 1'b1;
                            e_kind = KIND_WOKEN;
                            e_tag  = i_head_cmd.tag;
                        end
                        CMD_WAIT: begin
                            emit  = 1'b1;
                            e_tag = i_head_cmd.tag;
                            if (free_found) begin
                                mem_we          = 1'b1;
                                n_occ[free_idx] = 1'b1;
                                e_kind          = KIND_REGISTERED;
                                e_slot          = slot_field(free_idx);
                            end else begin
                                e_kind = KIND_REJECTED;
                            end
                        end
                        CMD_WAKE: begin
                            n_pend  = r_occ;
                            n_cnt   = i_head_cmd.count;
                            n_state = ST_SCAN;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (pend_found) begin
                    rd_en            = 1'b1;
                    n_idx            = pend_idx;
                    n_pend[pend_idx] = 1'b0;
                    n_state          = ST_CMP;
                end else begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_CMP: begin
                if (r_rd_thr <= r_cnt) begin
                    emit         = 1'b1;
                    e_kind       = KIND_WOKEN;
                    e_slot       = slot_field(r_idx);
                    e_tag        = r_rd_tag;
                    e_last       = 1'b0;
                    n_occ[r_idx] = 1'b0;
                end
                n_state = ST_SCAN;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_pend      <= n_pend;
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_idx       <= n_idx;
        r_out_kind  <= e_kind;
        r_out_slot  <= e_slot;
        r_out_tag   <= e_tag;
        r_out_count <= e_count;
        r_out_last  <= e_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_thr_mem[free_idx] <= i_head_cmd.threshold;
            r_tag_mem[free_idx] <= i_head_cmd.tag;
        end
        if (rd_en) begin
            r_rd_thr <= r_thr_mem[pend_idx];
            r_rd_tag <= r_tag_mem[pend_idx];
        end
    end

endmodule

// ===== rtl/twc_checker.sv =====
// Port-level assertions for the threshold wait counter and their binding.
module twc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_busy,
    input logic                             o_result_valid,
    input logic [twc_pkg::KIND_W-1:0]       o_result_kind,
    input logic [twc_pkg::SLOT_FIELD_W-1:0] o_slot_index,
    input logic [twc_pkg::TAG_W-1:0]        o_woken_tag,
    input logic                             o_last
);
    import twc_pkg::*;
`include "threshold_wait_counter_defines.svh"

    // A result that is not the final one of a request can only be a wake.
    `TWC_ASSERT_IMP(a_mid_is_wake, i_clk, i_rst_n, o_result_valid && !o_last, o_result_kind == KIND_WOKEN, "non-final result is not a wake")

    // An acknowledge closes its request and carries no slot and no tag.
    `TWC_ASSERT_IMP(a_ack_shape, i_clk, i_rst_n, o_result_valid && o_result_kind == KIND_ACK, o_last && o_slot_index == '0 && o_woken_tag == '0, "malformed acknowledge")

    // A wake during a scan is followed by a cycle without a result or by the closing acknowledge.
    `TWC_ASSERT_NXT(a_wake_gap, i_clk, i_rst_n, o_result_valid && !o_last, !o_result_valid || o_result_kind == KIND_ACK, "results back to back during wake scan")

    // Reset leaves no result strobe and no busy indication behind.
    `TWC_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n, !o_result_valid && !o_busy, "activity right after reset")

endmodule

bind threshold_wait_counter twc_checker u_twc_checker (.*);

// ===== dv/threshold_wait_counter_tb.sv =====
// Self-checking testbench for the threshold wait counter: directed table, random bursts.
`timescale 1ns / 100ps

module threshold_wait_counter_tb;
    import twc_pkg::*;

    localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;
    localparam logic [VAL_W-1:0] ALL_ONES  = '1;
    localparam logic [VAL_W-1:0] TOP_BIT   = {1'b1, {(VAL_W-1){1'b0}}};
    localparam int RANDOM_ITEMS   = 350;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_DIRECTED   = 24;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [TAG_W-1:0]        tag;
        logic [VAL_W-1:0]        count;
        logic                    last;
    } twc_result_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [VAL_W-1:0] operand;
        logic [TAG_W-1:0] tag;
        logic             typed;
        twc_result_t      want;
    } stim_row_t;

    localparam twc_result_t NO_WANT = '0;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_start;
    logic                    o_busy;
    logic [REQ_W-1:0]        i_req_type;
    logic [VAL_W-1:0]        i_operand_value;
    logic [TAG_W-1:0]        i_requester_tag;
    logic                    o_result_valid;
    logic [KIND_W-1:0]       o_result_kind;
    logic [SLOT_FIELD_W-1:0] o_slot_index;
    logic [TAG_W-1:0]        o_woken_tag;
    logic [VAL_W-1:0]        o_counter_value;
    logic                    o_last;

    logic [VAL_W-1:0] counter_mirror;
    logic [VAL_W-1:0] waiter_threshold [WAIT_SLOTS];
    logic [TAG_W-1:0] waiter_tag [WAIT_SLOTS];
    twc_result_t      pending_results [$];
    int               mismatch_count;
    bit               sender_idles;

    // Entries that read as "typed" carry the result expected from the request alone.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{REQ_READ,  ALL_ONES,   8'hFF, 1'b1, '{KIND_ACK, 5'd0, 8'h00, 64'd0, 1'b1}},
        '{REQ_WAIT,  64'd0,      8'hA5, 1'b1, '{KIND_WOKEN, 5'd0, 8'hA5, 64'd0, 1'b1}},
        '{REQ_WAIT,  64'd5,      8'h11, 1'b1, '{KIND_REGISTERED, 5'd0, 8'h11, 64'd0, 1'b1}},
        '{REQ_WAIT,  ALL_ONES,   8'hFF, 1'b1, '{KIND_REGISTERED, 5'd1, 8'hFF, 64'd0, 1'b1}},
        '{REQ_WAIT,  64'd3,      8'h00, 1'b1, '{KIND_REGISTERED, 5'd2, 8'h00, 64'd0, 1'b1}},
        '{REQ_INC,   64'd0,      8'h00, 1'b0, NO_WANT},
        '{REQ_RAISE, 64'd2,      8'h00, 1'b0, NO_WANT},
        '{REQ_RAISE, 64'd1,      8'h5A, 1'b1, '{KIND_ACK, 5'd0, 8'h00, 64'd2, 1'b1}},
        '{REQ_SET,   64'd4,      8'h00, 1'b0, NO_WANT},
        '{REQ_INC,   ALL_ONES,   8'hFF, 1'b0, NO_WANT},
        '{REQ_WAIT,  64'd5,      8'h44, 1'b1, '{KIND_WOKEN, 5'd0, 8'h44, 64'd5, 1'b1}},
        '{REQ_WAIT,  64'd6,      8'h66, 1'b1, '{KIND_REGISTERED, 5'd0, 8'h66, 64'd5, 1'b1}},
        '{REQ_WAIT,  64'd6,      8'h67, 1'b1, '{KIND_REGISTERED, 5'd2, 8'h67, 64'd5, 1'b1}},
        '{REQ_RAISE, 64'd6,      8'h00, 1'b0, NO_WANT},
        '{REQ_SET,   ALL_ONES,   8'h00, 1'b0, NO_WANT},
        '{REQ_INC,   64'd0,      8'h00, 1'b1, '{KIND_ACK, 5'd0, 8'h00, 64'd0, 1'b1}},
        '{REQ_RAISE, 64'd0,      8'h00, 1'b1, '{KIND_ACK, 5'd0, 8'h00, 64'd0, 1'b1}},
        '{REQ_RSVD5, ALL_ONES,   8'hFF, 1'b1, '{KIND_ACK, 5'd0, 8'h00, 64'd0, 1'b1}},
        '{REQ_RSVD6, 64'd9,      8'h01, 1'b1, '{KIND_ACK, 5'd0, 8'h00, 64'd0, 1'b1}},
        '{REQ_RSVD7, TOP_BIT,    8'h80, 1'b1, '{KIND_ACK, 5'd0, 8'h00, 64'd0, 1'b1}},
        '{REQ_WAIT,  TOP_BIT,    8'h80, 1'b1, '{KIND_REGISTERED, 5'd0, 8'h80, 64'd0, 1'b1}},
        '{REQ_SET,   ~TOP_BIT,   8'h00, 1'b1, '{KIND_ACK, 5'd0, 8'h00, ~TOP_BIT, 1'b1}},
        '{REQ_RAISE, TOP_BIT,    8'h00, 1'b0, NO_WANT},
        '{REQ_SET,   64'd0,      8'h00, 1'b0, NO_WANT}
    };

    threshold_wait_counter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_req_type      (i_req_type),
        .i_operand_value (i_operand_value),
        .i_requester_tag (i_requester_tag),
        .o_result_valid  (o_result_valid),
        .o_result_kind   (o_result_kind),
        .o_slot_index    (o_slot_index),
        .o_woken_tag     (o_woken_tag),
        .o_counter_value (o_counter_value),
        .o_last          (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic push_result(input logic [KIND_W-1:0] kind, input int slot,
                               input logic [TAG_W-1:0] tag, input logic last);
        twc_result_t r;
        r.kind  = kind;
        r.slot  = SLOT_FIELD_W'(slot);
        r.tag   = tag;
        r.count = counter_mirror;
        r.last  = last;
        pending_results.push_back(r);
    endtask

    task automatic wake_met_waiters();
        for (int i = 0; i < WAIT_SLOTS; i++) begin
            if (waiter_threshold[i] != '0 && waiter_threshold[i] <= counter_mirror) begin
                push_result(KIND_WOKEN, i, waiter_tag[i], 1'b0);
                waiter_threshold[i] = '0;
            end
        end
        push_result(KIND_ACK, 0, '0, 1'b1);
    endtask

    task automatic predict_counter_results(input logic [REQ_W-1:0] req,
                                           input logic [VAL_W-1:0] opnd,
                                           input logic [TAG_W-1:0] tag);
        int free_slot;
        free_slot = -1;
        case (req)
            REQ_SET: begin
                counter_mirror = opnd;
                wake_met_waiters();
            end
            REQ_RAISE: begin
                if (counter_mirror < opnd) begin
                    counter_mirror = opnd;
                    wake_met_waiters();
                end else begin
                    push_result(KIND_ACK, 0, '0, 1'b1);
                end
            end
            REQ_INC: begin
                counter_mirror = counter_mirror + 1'b1;
                wake_met_waiters();
            end
            REQ_WAIT: begin
                if (counter_mirror >= opnd) begin
                    push_result(KIND_WOKEN, 0, tag, 1'b1);
                end else begin
                    for (int i = WAIT_SLOTS - 1; i >= 0; i--) begin
                        if (waiter_threshold[i] == '0) free_slot = i;
                    end
                    if (free_slot >= 0) begin
                        waiter_threshold[free_slot] = opnd;
                        waiter_tag[free_slot]       = tag;
                        push_result(KIND_REGISTERED, free_slot, tag, 1'b1);
                    end else begin
                        push_result(KIND_REJECTED, 0, tag, 1'b1);
                    end
                end
            end
            default: push_result(KIND_ACK, 0, '0, 1'b1);
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic issue_request(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] opnd,
                                 input logic [TAG_W-1:0] tag, input logic typed,
                                 input twc_result_t want);
        int depth_before;
        while (sender_idles && $urandom_range(0, 99) < 21) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start         <= 1'b1;
        i_req_type      <= req;
        i_operand_value <= opnd;
        i_requester_tag <= tag;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        depth_before = pending_results.size();
        predict_counter_results(req, opnd, tag);
        if (typed) begin
            while (pending_results.size() > depth_before) void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_operand();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return {$urandom, $urandom};
            3:       return counter_mirror + VAL_W'($urandom_range(0, 40));
            4:       return counter_mirror - VAL_W'($urandom_range(0, 40));
            default: return ALL_ONES - VAL_W'($urandom_range(0, 40));
        endcase
    endfunction

    always @(posedge i_clk) begin : check_results
        twc_result_t got;
        twc_result_t want;
        if (i_rst_n && o_result_valid) begin
            got = '{o_result_kind, o_slot_index, o_woken_tag, o_counter_value, o_last};
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d slot=%0d tag=%02h",
                                          got.kind, got.slot, got.tag));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf(
                        "kind %0d/%0d slot %0d/%0d tag %02h/%02h count %h/%h last %b/%b",
                        got.kind, want.kind, got.slot, want.slot, got.tag, want.tag,
                        got.count, want.count, got.last, want.last));
                end
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_start && !o_busy) || o_result_valid) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("watchdog expired with %0d results outstanding", pending_results.size());
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int random_sent;
        int burst;
        int reps;
        logic [REQ_W-1:0] req;
        logic [VAL_W-1:0] opnd;

        mismatch_count  = 0;
        sender_idles    = 1'b1;
        counter_mirror  = '0;
        for (int i = 0; i < WAIT_SLOTS; i++) begin
            waiter_threshold[i] = '0;
            waiter_tag[i]       = '0;
        end
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_req_type      = REQ_READ;
        i_operand_value = '0;
        i_requester_tag = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            issue_request(directed_rows[k].req, directed_rows[k].operand, directed_rows[k].tag,
                          directed_rows[k].typed, directed_rows[k].want);
        end

        // Most bursts fill the waiter table and then move the counter past the
        // thresholds; the rest are unstructured requests of any type.
        random_sent = 0;
        burst       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (burst == 0 || $urandom_range(0, 9) < 6) begin
                reps = (burst == 0) ? WAIT_SLOTS + 2 : $urandom_range(3, 36);
                repeat (reps) begin
                    sender_idles = !(random_sent >= 120 && random_sent < 200);
                    opnd = ($urandom_range(0, 9) < 8) ?
                           counter_mirror + VAL_W'($urandom_range(1, 60)) : pick_operand();
                    issue_request(REQ_WAIT, opnd, TAG_W'($urandom_range(0, 255)), 1'b0, NO_WANT);
                    random_sent++;
                end
                repeat ($urandom_range(1, 4)) begin
                    sender_idles = !(random_sent >= 120 && random_sent < 200);
                    case ($urandom_range(0, 3))
                        0: begin
                            req  = REQ_INC;
                            opnd = {$urandom, $urandom};
                        end
                        1: begin
                            req  = REQ_RAISE;
                            opnd = counter_mirror + VAL_W'($urandom_range(0, 40));
                        end
                        2: begin
                            req  = REQ_SET;
                            opnd = counter_mirror + VAL_W'($urandom_range(1, 60));
                        end
                        default: begin
                            req  = REQ_SET;
                            opnd = pick_operand();
                        end
                    endcase
                    issue_request(req, opnd, TAG_W'($urandom_range(0, 255)), 1'b0, NO_WANT);
                    random_sent++;
                end
            end else begin
                repeat ($urandom_range(5, 15)) begin
                    sender_idles = !(random_sent >= 120 && random_sent < 200);
                    issue_request(REQ_W'($urandom_range(0, 7)), pick_operand(),
                                  TAG_W'($urandom_range(0, 255)), 1'b0, NO_WANT);
                    random_sent++;
                end
            end
            burst++;
        end
        i_start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
